// File: hw/rtl/jvs_pkg.sv
// ----------------------------------------------------------------------------
// jvs_pkg
// Shared widths, codes, bus layout helpers and the controller/datapath link
// types of the joystick velocity shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jvs_pkg;

   localparam int SAMPLE_BITS_DEF = 16;

   // configuration registers
   localparam int SET_W     = 48;
   localparam int LIM_W     = 16;
   localparam int MAXIN_W   = 16;
   localparam int DZ_W      = 16;
   localparam int GAIN_W    = 16;
   localparam int DZ_FRAC   = 15;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRIP_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRIP_HIGH = 3'd4;

   // item kinds
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
   localparam logic [OP_W-1:0] OP_POSITION = 2'd1;
   localparam logic [OP_W-1:0] OP_MODE     = 2'd2;

   localparam int MODE_W = 8;
   localparam logic [MODE_W-1:0] MODE_ACTIVE = 8'd2;
   localparam int POS_W = 16;

   // trigger gain of 1.0 in Q1.15
   localparam logic [GAIN_W-1:0] TRIG_GAIN = 16'h8000;

   // result fields
   localparam int VEL_W  = 17;
   localparam int TURN_W = 2;
   localparam int CMD_W  = 17;
   localparam int RSP_TURN_LSB    = 3 * VEL_W;
   localparam int RSP_CMD_LSB     = RSP_TURN_LSB + TURN_W;
   localparam int RSP_UNKNOWN_BIT = RSP_CMD_LSB + CMD_W;
   localparam int RSP_FIELDS_W    = RSP_UNKNOWN_BIT + 1;
   localparam int RSP_DATA_W      = ((RSP_FIELDS_W + 7) / 8) * 8;

   // divider: 16 quotient bits, two per cycle
   localparam int QUO_W     = 16;
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // shaping slots, one per shaped value
   localparam int NUM_SHAPES = 5;
   localparam int SLOT_W     = 3;
   localparam logic [SLOT_W-1:0] SLOT_X     = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_Y     = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_Z     = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_OPEN  = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_CLOSE = 3'd4;

   function automatic int req_fields_w(int sb);
      return 5 * sb + 3 + POS_W + MODE_W;
   endfunction

   function automatic int req_data_w(int sb);
      return ((req_fields_w(sb) + 7) / 8) * 8;
   endfunction

   typedef struct packed {
      logic              accept;
      logic              shape_load;
      logic              shape_mul;
      logic              shape_prep;
      logic              shape_div;
      logic              shape_store;
      logic              emit;
      logic [SLOT_W-1:0] slot;
   } jvs_cmd_type;

   typedef struct packed {
      logic is_sample;
      logic item_active;
      logic out_free;
   } jvs_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/joystick_velocity_shaper.sv
// ----------------------------------------------------------------------------
// joystick_velocity_shaper
// Shapes joystick samples into x/y/z velocity commands, a joint-six turn
// direction and a limit-guarded gripper command.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  req_      in         req_tvalid / req_tready   tuser: op; tdata: sample,
//                                                  position report, mode
//  rsp_      out        rsp_tvalid / rsp_tready   tdata: shaped result
//  csr_      in         csr_we (no wait)          csr_index, csr_wdata
//
//  A joystick sample is shaped after its transfer: five shaped values share
//  one unit, each passed through load, multiply, prepare, divide and store,
//  with the radix-4 divider resolving 16 quotient bits. Position reports
//  and mode updates finish in the transfer cycle and leave req_tready
//  high. Reset is synchronous, active high, and clears configuration,
//  block state and both handshakes. A stalled result holds in the output
//  register while the next sample is taken and shaped.
//
`default_nettype none

module joystick_velocity_shaper #(
   parameter int SAMPLE_BITS = jvs_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   // request channel
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   // tdata, from bit 0: stick_x, stick_y, stick_z, trigger_open,
   // trigger_close, button_right, button_left, sample_complete,
   // position_report, mode_value, zero fill
   input  wire logic [jvs_pkg::req_data_w(SAMPLE_BITS)-1:0] req_tdata,
   // tuser: op
   input  wire logic [jvs_pkg::OP_W-1:0]                    req_tuser,
   // response channel
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // tdata, from bit 0: velocity_x, velocity_y, velocity_z, joint_turn,
   // grip_drive, gripper_unknown, zero fill
   output logic [jvs_pkg::RSP_DATA_W-1:0]                   rsp_tdata,
   // configuration write port
   input  wire logic                                        csr_we,
   input  wire logic [jvs_pkg::CSR_IDX_W-1:0]               csr_index,
   input  wire logic [jvs_pkg::SET_W-1:0]                   csr_wdata
);
   import jvs_pkg::*;

   jvs_cmd_type    cmd;
   jvs_status_type status;

   // sequencer: owns req_tready and steps the shaping unit
   jvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: registers, shaping unit, gripper guard, output register
   jvs_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   // reports, mode updates and undefined kinds finish in the transfer cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != OP_SAMPLE) |=> req_tready)
      else $error("ready dropped after a non-sample transfer");

   // a sample occupies the sequencer until its result is emitted
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_SAMPLE) |=> !req_tready)
      else $error("ready held after a sample transfer");

   // a new result only appears out of the emit step, never while idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised without a sample in flight");

   // an unknown gripper position always zeroes the command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_UNKNOWN_BIT]) |->
         (rsp_tdata[RSP_CMD_LSB +: CMD_W] == '0))
      else $error("gripper command nonzero with unknown position");

endmodule

`default_nettype wire

// File: hw/rtl/jvs_ctrl.sv
// ----------------------------------------------------------------------------
// jvs_ctrl
// Sequencer: accepts items, walks the five shaping slots of an active sample
// through load, multiply, prepare, divide and store, then emits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module jvs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire jvs_pkg::jvs_status_type status,
   output jvs_pkg::jvs_cmd_type        cmd
);
   import jvs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_STORE,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic                  ready_ff;
   logic                  accept;

   assign accept     = req_tvalid & ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.shape_load  = (state_ff == ST_LOAD);
      cmd.shape_mul   = (state_ff == ST_MUL);
      cmd.shape_prep  = (state_ff == ST_PREP);
      cmd.shape_div   = (state_ff == ST_DIV);
      cmd.shape_store = (state_ff == ST_STORE);
      cmd.emit        = (state_ff == ST_EMIT) & status.out_free;
      cmd.slot        = slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= SLOT_X;
         cnt_ff   <= '0;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && status.is_sample) begin
                  ready_ff <= 1'b0;
                  slot_ff  <= SLOT_X;
                  state_ff <= status.item_active ? ST_LOAD : ST_EMIT;
               end
            end
            ST_LOAD: state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_PREP;
            ST_PREP: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: begin
               if (slot_ff == SLOT_CLOSE) begin
                  state_ff <= ST_EMIT;
               end else begin
                  slot_ff  <= slot_ff + 1'b1;
                  state_ff <= ST_LOAD;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/jvs_datapath.sv
// ----------------------------------------------------------------------------
// jvs_datapath
// Item and configuration registers, the shared shaping unit (clamp,
// dead-zone test, gain multiply, radix-4 restoring divider) and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jvs_datapath #(
   parameter int SAMPLE_BITS = jvs_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic [jvs_pkg::req_data_w(SAMPLE_BITS)-1:0]   req_tdata,
   input  wire logic [jvs_pkg::OP_W-1:0]                      req_tuser,
   input  wire logic                                          rsp_tready,
   output logic                                               rsp_tvalid,
   output logic [jvs_pkg::RSP_DATA_W-1:0]                     rsp_tdata,
   input  wire logic                                          csr_we,
   input  wire logic [jvs_pkg::CSR_IDX_W-1:0]                 csr_index,
   input  wire logic [jvs_pkg::SET_W-1:0]                     csr_wdata,
   input  wire jvs_pkg::jvs_cmd_type                          cmd,
   output jvs_pkg::jvs_status_type                            status
);
   import jvs_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int W   = SB + 16;
   localparam int XW  = W + 18;
   localparam int OFF_BR   = 5 * SB;
   localparam int OFF_BL   = OFF_BR + 1;
   localparam int OFF_CMPL = OFF_BR + 2;
   localparam int OFF_POS  = OFF_BR + 3;
   localparam int OFF_MODE = OFF_POS + POS_W;

   // configuration
   logic [SET_W-1:0]        axis_set_ff [3];
   logic signed [LIM_W-1:0] grip_lo_ff;
   logic signed [LIM_W-1:0] grip_hi_ff;

   // block state
   logic signed [POS_W-1:0] pos_ff;
   logic                    known_ff;
   logic [MODE_W-1:0]       mode_ff;

   // latched sample
   logic signed [SB-1:0]    smp_ff [NUM_SHAPES];
   logic                    btn_r_ff;
   logic                    btn_l_ff;
   logic                    active_ff;

   // shaping unit
   logic [W-1:0]            an_ff, ad_ff, a_ff;
   logic                    neg_ff;
   logic [DZ_W-1:0]         dz_ff;
   logic [GAIN_W-1:0]       g_ff;
   logic [W+GAIN_W-1:0]     agp_ff, dzp_ff;
   logic                    zero_ff;
   logic [W:0]              r_ff, dv_ff;
   logic [QUO_W-1:0]        xlo_ff, q_ff;
   logic signed [VEL_W-1:0] res_ff [NUM_SHAPES];

   // output register
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   logic [OP_W-1:0]         op;
   assign op = req_tuser;

   assign status.is_sample   = (op == OP_SAMPLE);
   assign status.item_active = (mode_ff == MODE_ACTIVE) & req_tdata[OFF_CMPL];
   assign status.out_free    = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- load: operand selection and magnitudes ----
   logic signed [SB-1:0]    s;
   logic [SET_W-1:0]        setting;
   logic                    is_trig;
   logic signed [SB:0]      s_ext;
   logic [SB:0]             s_mag;
   logic signed [SB+1:0]    one_minus;
   logic signed [MAXIN_W:0] m_ext;
   logic [MAXIN_W:0]        m_mag;
   logic [W-1:0]            m_w;
   logic [W-1:0]            an_in, ad_in;
   logic                    neg_in;

   always_comb begin
      s       = smp_ff[cmd.slot];
      is_trig = (cmd.slot == SLOT_OPEN) || (cmd.slot == SLOT_CLOSE);
      case (cmd.slot)
         SLOT_Y:  setting = axis_set_ff[1];
         SLOT_Z:  setting = axis_set_ff[2];
         default: setting = axis_set_ff[0];
      endcase
      s_ext     = {s[SB-1], s};
      s_mag     = s_ext[SB] ? (SB+1)'(-s_ext) : (SB+1)'(s_ext);
      one_minus = (SB+2)'(1) << (SB - 1);
      one_minus = one_minus - {s_ext[SB], s_ext};
      m_ext     = {setting[MAXIN_W-1], setting[MAXIN_W-1:0]};
      m_mag     = m_ext[MAXIN_W] ? (MAXIN_W+1)'(-m_ext) : (MAXIN_W+1)'(m_ext);
      m_w       = W'(m_mag);
      if (is_trig) begin
         an_in  = {one_minus[SB:0], {DZ_FRAC{1'b0}}};
         ad_in  = m_w << SB;
         neg_in = setting[MAXIN_W-1];
      end else begin
         an_in  = {s_mag, {DZ_FRAC{1'b0}}};
         ad_in  = m_w << (SB - 1);
         neg_in = s[SB-1] ^ setting[MAXIN_W-1];
      end
      // x velocity is the negated axis
      neg_in = neg_in ^ (cmd.slot == SLOT_X);
   end

   // ---- multiply: clamp then products ----
   logic [W-1:0] a_min;
   assign a_min = (an_ff < ad_ff) ? an_ff : ad_ff;

   // ---- prepare: dead zone and dividend ----
   logic         dead;
   logic [XW-1:0] x_in;
   assign dead = {1'b0, a_ff, {DZ_FRAC{1'b0}}} < dzp_ff;
   assign x_in = {1'b0, agp_ff, 1'b0} + {{(XW-W){1'b0}}, ad_ff};

   // ---- divide: two restoring steps ----
   logic [W+1:0] t1, t2, dv_x;
   logic [W:0]   r1, r2;
   logic         ge1, ge2;
   always_comb begin
      dv_x = {1'b0, dv_ff};
      t1   = {r_ff, xlo_ff[QUO_W-1]};
      ge1  = (t1 >= dv_x);
      r1   = ge1 ? (W+1)'(t1 - dv_x) : t1[W:0];
      t2   = {r1, xlo_ff[QUO_W-2]};
      ge2  = (t2 >= dv_x);
      r2   = ge2 ? (W+1)'(t2 - dv_x) : t2[W:0];
   end

   // ---- store ----
   logic [QUO_W-1:0]        mag;
   logic signed [VEL_W-1:0] val;
   assign mag = zero_ff ? '0 : q_ff;
   assign val = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   // ---- emit: gripper limit and result packing ----
   logic signed [CMD_W:0]    cmd_raw, cmd_lim;
   logic                     unknown;
   logic signed [TURN_W-1:0] turn;
   logic [RSP_DATA_W-1:0]    rsp_in;
   always_comb begin
      cmd_raw = {res_ff[SLOT_OPEN][VEL_W-1], res_ff[SLOT_OPEN]}
              - {res_ff[SLOT_CLOSE][VEL_W-1], res_ff[SLOT_CLOSE]};
      cmd_lim = cmd_raw;
      unknown = 1'b0;
      if (cmd_raw != '0) begin
         if (!known_ff) begin
            cmd_lim = '0;
            unknown = 1'b1;
         end else if (cmd_raw > 0 && pos_ff >= grip_hi_ff) begin
            cmd_lim = '0;
         end else if (cmd_raw < 0 && pos_ff <= grip_lo_ff) begin
            cmd_lim = '0;
         end
      end
      turn   = $signed({1'b0, btn_l_ff}) - $signed({1'b0, btn_r_ff});
      rsp_in = '0;
      if (active_ff) begin
         rsp_in[RSP_FIELDS_W-1:0] = {unknown, cmd_lim[CMD_W-1:0], turn,
                                     res_ff[SLOT_Z], res_ff[SLOT_Y], res_ff[SLOT_X]};
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_set_ff[0] <= '0;
         axis_set_ff[1] <= '0;
         axis_set_ff[2] <= '0;
         grip_lo_ff     <= '0;
         grip_hi_ff     <= '0;
         pos_ff         <= '0;
         known_ff       <= 1'b0;
         mode_ff        <= '0;
         active_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_AXIS_X:    axis_set_ff[0] <= csr_wdata;
               CSR_AXIS_Y:    axis_set_ff[1] <= csr_wdata;
               CSR_AXIS_Z:    axis_set_ff[2] <= csr_wdata;
               CSR_GRIP_LOW:  grip_lo_ff     <= csr_wdata[LIM_W-1:0];
               CSR_GRIP_HIGH: grip_hi_ff     <= csr_wdata[LIM_W-1:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            case (op)
               OP_POSITION: begin
                  pos_ff   <= req_tdata[OFF_POS +: POS_W];
                  known_ff <= 1'b1;
               end
               OP_MODE:   mode_ff   <= req_tdata[OFF_MODE +: MODE_W];
               OP_SAMPLE: active_ff <= status.item_active;
               default: ;
            endcase
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept && op == OP_SAMPLE) begin
         for (int i = 0; i < NUM_SHAPES; i++) begin
            smp_ff[i] <= req_tdata[i*SB +: SB];
         end
         btn_r_ff <= req_tdata[OFF_BR];
         btn_l_ff <= req_tdata[OFF_BL];
      end
      if (cmd.shape_load) begin
         an_ff  <= an_in;
         ad_ff  <= ad_in;
         neg_ff <= neg_in;
         dz_ff  <= setting[MAXIN_W +: DZ_W];
         g_ff   <= is_trig ? TRIG_GAIN : setting[MAXIN_W+DZ_W +: GAIN_W];
      end
      if (cmd.shape_mul) begin
         a_ff   <= a_min;
         agp_ff <= {{GAIN_W{1'b0}}, a_min} * {{W{1'b0}}, g_ff};
         dzp_ff <= {{W{1'b0}}, dz_ff} * {{GAIN_W{1'b0}}, ad_ff};
      end
      if (cmd.shape_prep) begin
         zero_ff <= dead | (ad_ff == '0);
         r_ff    <= x_in[W+QUO_W:QUO_W];
         xlo_ff  <= x_in[QUO_W-1:0];
         dv_ff   <= {ad_ff, 1'b0};
         q_ff    <= '0;
      end
      if (cmd.shape_div) begin
         r_ff   <= r2;
         xlo_ff <= {xlo_ff[QUO_W-3:0], 2'b00};
         q_ff   <= {q_ff[QUO_W-3:0], ge1, ge2};
      end
      if (cmd.shape_store) begin
         res_ff[cmd.slot] <= val;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
